// File: hdl/mlp_pkg.sv
package mlp_pkg;

  // Request modes.
  localparam logic [2:0] MODE_W1     = 3'd0;
  localparam logic [2:0] MODE_W2     = 3'd1;
  localparam logic [2:0] MODE_HBIAS  = 3'd2;
  localparam logic [2:0] MODE_OBIAS  = 3'd3;
  localparam logic [2:0] MODE_SAMPLE = 3'd4;

  // Configuration register indexes.
  localparam logic [1:0] CFG_INPUTS  = 2'd0;
  localparam logic [1:0] CFG_HIDDEN  = 2'd1;
  localparam logic [1:0] CFG_OUTPUTS = 2'd2;

  localparam int CFG_W   = 5;
  localparam int VAL_W   = 16;
  localparam int ACT_W   = 13;
  localparam int PROD_W  = 33;
  localparam int ACC_W   = 48;
  localparam int OUT_LIM = 16;

  localparam logic [63:0] ONE_Q30  = 64'd1 << 30;
  localparam logic [63:0] SIG_STEP = 64'd1008687097;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_BIAS,
    OP_MAC,
    OP_FIN
  } mlp_op_t;

  typedef struct packed {
    mlp_op_t op;
    logic    layer;     // 0 hidden layer, 1 output layer
    logic    last_out;
  } mlp_cmd_t;

  typedef struct packed {
    logic busy;
    logic out_full;
  } mlp_stat_t;

  typedef logic [ACT_W-1:0] sig_table_t [256];

  // Shift-and-subtract quotient, used only while the table is elaborated.
  function automatic logic [63:0] div_u64(logic [63:0] num, logic [63:0] dvs);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], num[b]};
      if (r >= {1'b0, dvs}) begin
        r    = r - {1'b0, dvs};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Logistic table over -8..8 in steps of 1/16, built at elaboration.
  function automatic sig_table_t build_sig_table();
    sig_table_t  tbl;
    logic [63:0] e [129];
    logic [63:0] den;
    e[0] = ONE_Q30;
    for (int m = 0; m < 128; m++) begin
      e[m+1] = (e[m] * SIG_STEP + (ONE_Q30 >> 1)) >> 30;
    end
    for (int k = 0; k < 256; k++) begin
      if (k >= 128) begin
        den    = ONE_Q30 + e[k-128];
        tbl[k] = ACT_W'(div_u64((64'd1 << 42) + (den >> 1), den));
      end else begin
        den    = ONE_Q30 + e[128-k];
        tbl[k] = ACT_W'(div_u64(e[128-k] * 64'd4096 + (den >> 1), den));
      end
    end
    return tbl;
  endfunction

  localparam sig_table_t SIG_TABLE = build_sig_table();

endpackage

// File: hdl/mlp_if.sv
interface mlp_req_if;
  logic              valid;
  logic              ready;
  logic [2:0]        mode;
  logic [3:0]        row;
  logic [3:0]        col;
  logic signed [15:0] value;
  logic              last;
  modport source(output valid, mode, row, col, value, last, input ready);
  modport sink(input valid, mode, row, col, value, last, output ready);
endinterface

interface mlp_res_if;
  logic        valid;
  logic        ready;
  logic [3:0]  out_index;
  logic [12:0] activation;
  logic        final_res;
  modport source(output valid, out_index, activation, final_res, input ready);
  modport sink(input valid, out_index, activation, final_res, output ready);
endinterface

// File: hdl/mlp_ram.sv
module mlp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/mlp_ctrl.sv
module mlp_ctrl
  import mlp_pkg::*;
#(
  parameter int MAX_INPUTS  = 16,
  parameter int MAX_HIDDEN  = 16,
  parameter int MAX_OUTPUTS = 16,
  parameter int SRC_W       = 4,
  parameter int DST_W       = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             req_valid,
  input  logic [2:0]       req_mode,
  input  logic             req_last,
  output logic             req_ready,
  output mlp_cmd_t         cmd,
  output logic [SRC_W-1:0] src_idx,
  output logic [DST_W-1:0] dst_idx,
  input  mlp_stat_t        stat
);

  localparam int OUT_MAX = (MAX_OUTPUTS < OUT_LIM) ? MAX_OUTPUTS : OUT_LIM;

  typedef enum logic [3:0] {
    IDLE, H_BIAS, H_MAC, H_FIN, H_DRAIN, O_WAIT, O_BIAS, O_MAC, O_FIN, DONE
  } state_t;

  state_t           state;
  logic [CFG_W-1:0] in_cnt;
  logic [CFG_W-1:0] hid_cnt;
  logic [CFG_W-1:0] out_cnt;
  int               ni;
  int               nh;
  int               no;
  logic             src_end_h;
  logic             src_end_o;
  logic             dst_end_h;
  logic             dst_end_o;

  always_comb begin
    ni = (in_cnt == '0) ? 1 : ((int'(in_cnt) > MAX_INPUTS) ? MAX_INPUTS : int'(in_cnt));
    nh = (hid_cnt == '0) ? 1 : ((int'(hid_cnt) > MAX_HIDDEN) ? MAX_HIDDEN : int'(hid_cnt));
    no = (out_cnt == '0) ? 1 : ((int'(out_cnt) > OUT_MAX) ? OUT_MAX : int'(out_cnt));
    src_end_h = (int'(src_idx) == ni - 1);
    src_end_o = (int'(src_idx) == nh - 1);
    dst_end_h = (int'(dst_idx) == nh - 1);
    dst_end_o = (int'(dst_idx) == no - 1);
  end

  assign req_ready = (state == IDLE);

  always_comb begin
    cmd.op       = OP_NONE;
    cmd.layer    = 1'b0;
    cmd.last_out = 1'b0;
    case (state)
      H_BIAS: cmd.op = OP_BIAS;
      H_MAC:  cmd.op = OP_MAC;
      H_FIN:  cmd.op = OP_FIN;
      O_BIAS: begin
        cmd.op    = OP_BIAS;
        cmd.layer = 1'b1;
      end
      O_MAC: begin
        cmd.op    = OP_MAC;
        cmd.layer = 1'b1;
      end
      O_FIN: begin
        cmd.op       = OP_FIN;
        cmd.layer    = 1'b1;
        cmd.last_out = dst_end_o;
      end
      default: cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= IDLE;
      in_cnt  <= CFG_W'(16);
      hid_cnt <= CFG_W'(16);
      out_cnt <= CFG_W'(16);
      src_idx <= '0;
      dst_idx <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_INPUTS:  in_cnt  <= cfg_data;
          CFG_HIDDEN:  hid_cnt <= cfg_data;
          CFG_OUTPUTS: out_cnt <= cfg_data;
          default:     ;
        endcase
      end
      case (state)
        IDLE: begin
          if (req_valid && req_mode == MODE_SAMPLE && req_last) begin
            dst_idx <= '0;
            state   <= H_BIAS;
          end
        end
        H_BIAS: begin
          src_idx <= '0;
          state   <= H_MAC;
        end
        H_MAC: begin
          src_idx <= src_idx + 1'b1;
          if (src_end_h) begin
            state <= H_FIN;
          end
        end
        H_FIN: begin
          if (dst_end_h) begin
            state <= H_DRAIN;
          end else begin
            dst_idx <= dst_idx + 1'b1;
            state   <= H_BIAS;
          end
        end
        H_DRAIN: begin
          // The output layer reads every hidden activation, so all must be written.
          if (!stat.busy) begin
            dst_idx <= '0;
            state   <= O_WAIT;
          end
        end
        O_WAIT: begin
          if (!stat.busy && !stat.out_full) begin
            state <= O_BIAS;
          end
        end
        O_BIAS: begin
          src_idx <= '0;
          state   <= O_MAC;
        end
        O_MAC: begin
          src_idx <= src_idx + 1'b1;
          if (src_end_o) begin
            state <= O_FIN;
          end
        end
        O_FIN: begin
          if (dst_end_o) begin
            state <= DONE;
          end else begin
            dst_idx <= dst_idx + 1'b1;
            state   <= O_WAIT;
          end
        end
        DONE: begin
          if (!stat.busy) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  a_ready_pipe_empty: assert property (@(posedge clk) disable iff (rst)
    req_ready |-> !stat.busy)
    else $error("request accepted while the pipeline is busy");

  a_out_layer_start: assert property (@(posedge clk) disable iff (rst)
    (state == O_BIAS) |-> (!stat.busy && !stat.out_full))
    else $error("output neuron started with results in flight");

  a_last_done: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_FIN && cmd.last_out) |=> (state == DONE))
    else $error("last output neuron did not end the evaluation");

endmodule

// File: hdl/mlp_dp.sv
module mlp_dp
  import mlp_pkg::*;
#(
  parameter int MAX_INPUTS  = 16,
  parameter int MAX_HIDDEN  = 16,
  parameter int MAX_OUTPUTS = 16,
  parameter int SRC_W       = 4,
  parameter int DST_W       = 4
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     ld_en,
  input  logic [2:0]               ld_mode,
  input  logic [3:0]               ld_row,
  input  logic [3:0]               ld_col,
  input  logic signed [VAL_W-1:0]  ld_value,
  input  mlp_cmd_t                 cmd,
  input  logic [SRC_W-1:0]         src_idx,
  input  logic [DST_W-1:0]         dst_idx,
  output mlp_stat_t                stat,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [3:0]               out_index,
  output logic [ACT_W-1:0]         out_act,
  output logic                     out_final
);

  localparam int W1_N  = MAX_HIDDEN * MAX_INPUTS;
  localparam int W2_N  = MAX_OUTPUTS * MAX_HIDDEN;
  localparam int W1_AW = W1_N > 1 ? $clog2(W1_N) : 1;
  localparam int W2_AW = W2_N > 1 ? $clog2(W2_N) : 1;
  localparam int IN_AW = MAX_INPUTS > 1 ? $clog2(MAX_INPUTS) : 1;
  localparam int HD_AW = MAX_HIDDEN > 1 ? $clog2(MAX_HIDDEN) : 1;
  localparam int OU_AW = MAX_OUTPUTS > 1 ? $clog2(MAX_OUTPUTS) : 1;

  logic               row_h_ok, row_o_ok, row_i_ok, col_i_ok, col_h_ok;
  logic               w1_we, w2_we, hb_we, ob_we, xv_we, hv_we;
  logic [VAL_W-1:0]   w1_q, w2_q, hb_q, ob_q, xv_q;
  logic [ACT_W-1:0]   hv_q;

  mlp_op_t            op1, op2;
  logic               layer1, layer2, layer3, layer4;
  logic               last1, last2, last3, last4;
  logic [DST_W-1:0]   dst1, dst2, dst3, dst4;
  logic               v3, v4;

  logic signed [VAL_W-1:0]  w_sel;
  logic signed [VAL_W-1:0]  b_sel;
  logic signed [VAL_W:0]    x_sel;
  logic signed [PROD_W-1:0] prod_next;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  rnd;
  logic signed [VAL_W-1:0]  q_next;
  logic signed [VAL_W-1:0]  q3;
  logic [ACT_W-1:0]         act4;

  assign row_h_ok = int'(ld_row) < MAX_HIDDEN;
  assign row_o_ok = int'(ld_row) < MAX_OUTPUTS;
  assign row_i_ok = int'(ld_row) < MAX_INPUTS;
  assign col_i_ok = int'(ld_col) < MAX_INPUTS;
  assign col_h_ok = int'(ld_col) < MAX_HIDDEN;

  assign w1_we = ld_en && ld_mode == MODE_W1 && row_h_ok && col_i_ok;
  assign w2_we = ld_en && ld_mode == MODE_W2 && row_o_ok && col_h_ok;
  assign hb_we = ld_en && ld_mode == MODE_HBIAS && row_h_ok;
  assign ob_we = ld_en && ld_mode == MODE_OBIAS && row_o_ok;
  assign xv_we = ld_en && ld_mode == MODE_SAMPLE && row_i_ok;
  assign hv_we = v4 && !layer4;

  mlp_ram #(.WIDTH(VAL_W), .DEPTH(W1_N)) u_w1 (
    .clk(clk), .we(w1_we),
    .waddr(W1_AW'(int'(ld_row) * MAX_INPUTS + int'(ld_col))),
    .wdata(ld_value),
    .raddr(W1_AW'(int'(dst_idx) * MAX_INPUTS + int'(src_idx))),
    .rdata(w1_q)
  );

  mlp_ram #(.WIDTH(VAL_W), .DEPTH(W2_N)) u_w2 (
    .clk(clk), .we(w2_we),
    .waddr(W2_AW'(int'(ld_row) * MAX_HIDDEN + int'(ld_col))),
    .wdata(ld_value),
    .raddr(W2_AW'(int'(dst_idx) * MAX_HIDDEN + int'(src_idx))),
    .rdata(w2_q)
  );

  mlp_ram #(.WIDTH(VAL_W), .DEPTH(MAX_HIDDEN)) u_hb (
    .clk(clk), .we(hb_we), .waddr(HD_AW'(ld_row)), .wdata(ld_value),
    .raddr(HD_AW'(dst_idx)), .rdata(hb_q)
  );

  mlp_ram #(.WIDTH(VAL_W), .DEPTH(MAX_OUTPUTS)) u_ob (
    .clk(clk), .we(ob_we), .waddr(OU_AW'(ld_row)), .wdata(ld_value),
    .raddr(OU_AW'(dst_idx)), .rdata(ob_q)
  );

  mlp_ram #(.WIDTH(VAL_W), .DEPTH(MAX_INPUTS)) u_xv (
    .clk(clk), .we(xv_we), .waddr(IN_AW'(ld_row)), .wdata(ld_value),
    .raddr(IN_AW'(src_idx)), .rdata(xv_q)
  );

  mlp_ram #(.WIDTH(ACT_W), .DEPTH(MAX_HIDDEN)) u_hv (
    .clk(clk), .we(hv_we), .waddr(HD_AW'(dst4)), .wdata(act4),
    .raddr(HD_AW'(src_idx)), .rdata(hv_q)
  );

  // Operand select and multiply; hidden activations are unsigned.
  always_comb begin
    w_sel = layer1 ? w2_q : w1_q;
    b_sel = layer1 ? ob_q : hb_q;
    x_sel = layer1 ? $signed({1'b0, hv_q[ACT_W-1:0], {(VAL_W-ACT_W){1'b0}}} >>> 0)
                   : $signed({xv_q[VAL_W-1], xv_q});
    if (layer1) begin
      x_sel = $signed({{(VAL_W+1-ACT_W){1'b0}}, hv_q});
    end
    if (op1 == OP_BIAS) begin
      prod_next = PROD_W'($signed({b_sel, 12'b0}));
    end else begin
      prod_next = PROD_W'(w_sel * x_sel);
    end
  end

  // Round half up to Q4.12 and saturate.
  always_comb begin
    rnd = (acc + ACC_W'(2048)) >>> 12;
    if (rnd > ACC_W'(32767)) begin
      q_next = 16'sh7FFF;
    end else if (rnd < -ACC_W'(32768)) begin
      q_next = -16'sh8000;
    end else begin
      q_next = rnd[VAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      op1       <= OP_NONE;
      op2       <= OP_NONE;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      op1 <= cmd.op;
      op2 <= op1;
      v3  <= (op2 == OP_FIN);
      v4  <= v3;
      if (v4 && layer4) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    layer1 <= cmd.layer;
    last1  <= cmd.last_out;
    dst1   <= dst_idx;
    layer2 <= layer1;
    last2  <= last1;
    dst2   <= dst1;
    prod   <= prod_next;
    layer3 <= layer2;
    last3  <= last2;
    dst3   <= dst2;
    layer4 <= layer3;
    last4  <= last3;
    dst4   <= dst3;
    case (op2)
      OP_BIAS: acc <= ACC_W'(prod);
      OP_MAC:  acc <= acc + ACC_W'(prod);
      default: acc <= acc;
    endcase
    if (op2 == OP_FIN) begin
      q3 <= q_next;
    end
    act4 <= SIG_TABLE[{~q3[VAL_W-1], q3[VAL_W-2:8]}];
    if (v4 && layer4) begin
      out_index <= 4'(dst4);
      out_act   <= act4;
      out_final <= last4;
    end
  end

  assign stat.busy     = (op1 != OP_NONE) || (op2 != OP_NONE) || v3 || v4;
  assign stat.out_full = out_valid;

  a_fin_after_mac: assert property (@(posedge clk) disable iff (rst)
    (op2 == OP_FIN) |-> ($past(op2) == OP_MAC))
    else $error("sum closed without a product");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (v4 && layer4) |-> (!out_valid || out_ready))
    else $error("result register overwritten before it was taken");

endmodule

// File: hdl/mlp_two_layer_sigmoid_inference_core.sv
// Channel | Dir | Payload                          | Accepted when
// req     | in  | mode, row, col, value, last      | req.valid && req.ready
// res     | out | out_index, activation, final_res | res.valid && res.ready
// cfg     | in  | cfg_index, cfg_data              | cfg_we
//
// Load requests and sample elements without last are accepted while the core is idle.
// A sample element with last runs both layers through one shared multiply-accumulate
// pipeline.
// Reset is synchronous and restores the counts to 16; the stores are undefined.
// A result waits in the output register; the next output neuron starts after it is taken.
module mlp_two_layer_sigmoid_inference_core
  import mlp_pkg::*;
#(
  parameter int MAX_INPUTS  = 16,
  parameter int MAX_HIDDEN  = 16,
  parameter int MAX_OUTPUTS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  mlp_req_if.sink          req,
  mlp_res_if.source        res
);

  localparam int SRC_N = MAX_INPUTS > MAX_HIDDEN ? MAX_INPUTS : MAX_HIDDEN;
  localparam int DST_N = MAX_HIDDEN > MAX_OUTPUTS ? MAX_HIDDEN : MAX_OUTPUTS;
  localparam int SRC_W = SRC_N > 1 ? $clog2(SRC_N) : 1;
  localparam int DST_W = DST_N > 1 ? $clog2(DST_N) : 1;

  mlp_cmd_t         cmd;
  mlp_stat_t        stat;
  logic [SRC_W-1:0] src_idx;
  logic [DST_W-1:0] dst_idx;
  logic             req_ready;

  assign req.ready = req_ready;

  mlp_ctrl #(
    .MAX_INPUTS(MAX_INPUTS), .MAX_HIDDEN(MAX_HIDDEN), .MAX_OUTPUTS(MAX_OUTPUTS),
    .SRC_W(SRC_W), .DST_W(DST_W)
  ) u_ctrl (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .req_valid(req.valid), .req_mode(req.mode), .req_last(req.last),
    .req_ready(req_ready),
    .cmd(cmd), .src_idx(src_idx), .dst_idx(dst_idx), .stat(stat)
  );

  mlp_dp #(
    .MAX_INPUTS(MAX_INPUTS), .MAX_HIDDEN(MAX_HIDDEN), .MAX_OUTPUTS(MAX_OUTPUTS),
    .SRC_W(SRC_W), .DST_W(DST_W)
  ) u_dp (
    .clk(clk), .rst(rst),
    .ld_en(req.valid && req_ready), .ld_mode(req.mode), .ld_row(req.row),
    .ld_col(req.col), .ld_value(req.value),
    .cmd(cmd), .src_idx(src_idx), .dst_idx(dst_idx), .stat(stat),
    .out_valid(res.valid), .out_ready(res.ready), .out_index(res.out_index),
    .out_act(res.activation), .out_final(res.final_res)
  );

endmodule
